>>> rtl/asj_pkg.sv
package asj_pkg;

   localparam int MAX_PROCS_DEF = 16;
   localparam int JOB_ID_W      = 5;
   localparam int PRIO_W        = 8;
   localparam int ARR_W         = 16;
   localparam int BURST_W       = 16;
   localparam int TIME_W        = 21;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 112;

   typedef struct packed {
      logic [JOB_ID_W-1:0] id;
      logic [PRIO_W-1:0]   prio;
      logic [ARR_W-1:0]    arr;
      logic [BURST_W-1:0]  burst;
   } job_rec_type;

   // what one cell shows its neighbours
   typedef struct packed {
      logic        valid;
      logic        disp;
      job_rec_type rec;
   } cell_link_type;

   typedef struct packed {
      job_rec_type       rec;
      logic [TIME_W-1:0] completion;
      logic [TIME_W-1:0] turnaround;
      logic [TIME_W-1:0] waiting;
      logic              last;
   } rsp_type;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } state_type;

   // x is scheduled ahead of y
   function automatic logic goes_before(job_rec_type x, job_rec_type y);
      logic r;
      if (x.arr != y.arr) begin
         r = (x.arr < y.arr);
      end else begin
         r = (x.prio > y.prio);
      end
      return r;
   endfunction

endpackage

>>> rtl/arrival_priority_job_scheduler.sv
// arrival-ordered job scheduler with priority tie-break, run without preemption
//
// req channel: one job record per request, tdata holds priority, arrival and
// burst; tlast marks the final record of a set and starts the run. records are
// taken one per cycle while loading and dropped once MAX_PROCS are held.
// each record enters a chain of cells kept sorted by arrival, higher priority
// first on equal arrival, load order on full ties. after the final record the
// chain shifts out one job per cycle toward the head while the receiver is
// ready; the final request moves the state to emit, then the first job is
// popped into the output register, and one result follows per cycle.
// rsp channel: one result per job with completion, turnaround and waiting
// ticks; tlast flags the final job. a stalled receiver holds the chain and
// the output register; the next set may load as soon as the chain is empty.
// reset empties the chain, clears the schedule clock and drops any result.
module arrival_priority_job_scheduler #(
   parameter int MAX_PROCS = asj_pkg::MAX_PROCS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // job_priority[7:0], arrival_time[23:8], burst_time[39:24]
   input  logic [asj_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // job_id[4:0], out_priority[12:5], out_arrival[28:13], out_burst[44:29],
   // completion_time[65:45], turnaround_time[86:66], waiting_time[107:87]
   output logic [asj_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import asj_pkg::*;

   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              accept, insert, pop, clear;
   job_rec_type       new_rec;
   cell_link_type     links [MAX_PROCS];
   cell_link_type     head_link;
   logic              rsp_valid;
   rsp_type           rsp;

   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign insert     = accept && (cnt_ff != CNT_W'(MAX_PROCS));
   assign clear      = accept && req_tlast;
   assign pop        = (state_ff == ST_EMIT) && (!rsp_valid || rsp_tready);

   assign new_rec.id    = JOB_ID_W'(cnt_ff) + JOB_ID_W'(1);
   assign new_rec.prio  = req_tdata[PRIO_W-1:0];
   assign new_rec.arr   = req_tdata[PRIO_W +: ARR_W];
   assign new_rec.burst = req_tdata[PRIO_W+ARR_W +: BURST_W];

   // the head sees an always-full neighbour that never displaces
   assign head_link.valid = 1'b1;
   assign head_link.disp  = 1'b0;
   assign head_link.rec   = '0;

   for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
      cell_link_type prev_l, next_l;
      if (i == 0) begin : g_head
         assign prev_l = head_link;
      end else begin : g_mid
         assign prev_l = links[i-1];
      end
      if (i == MAX_PROCS - 1) begin : g_tail
         assign next_l = '0;
      end else begin : g_body
         assign next_l = links[i+1];
      end
      asj_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .insert    (insert),
         .pop       (pop),
         .new_rec   (new_rec),
         .prev_link (prev_l),
         .next_link (next_l),
         .link      (links[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_LOAD: begin
            if (insert) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (clear) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (pop) begin
               cnt_in = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   asj_timer u_timer (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .load      (pop),
      .pop_rec   (links[0].rec),
      .pop_last  (cnt_ff == CNT_W'(1)),
      .rsp_taken (rsp_tready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tlast  = rsp.last;
   assign rsp_tdata  = {4'b0000, rsp.waiting, rsp.turnaround, rsp.completion,
                        rsp.rec.burst, rsp.rec.arr, rsp.rec.prio, rsp.rec.id};

endmodule

>>> rtl/asj_cell.sv
module asj_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  insert,
   input  logic                  pop,
   input  asj_pkg::job_rec_type  new_rec,
   input  asj_pkg::cell_link_type prev_link,
   input  asj_pkg::cell_link_type next_link,
   output asj_pkg::cell_link_type link
);
   import asj_pkg::*;

   logic        valid_ff, valid_in;
   job_rec_type rec_ff, rec_in;
   logic        disp;

   assign disp = valid_ff && goes_before(new_rec, rec_ff);

   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      if (pop) begin
         // chain moves one place toward the head
         valid_in = next_link.valid;
         rec_in   = next_link.rec;
      end else if (insert) begin
         if (prev_link.disp) begin
            valid_in = 1'b1;
            rec_in   = prev_link.rec;
         end else if (disp || (!valid_ff && prev_link.valid)) begin
            valid_in = 1'b1;
            rec_in   = new_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rec_ff <= rec_in;
   end

   assign link.valid = valid_ff;
   assign link.disp  = disp;
   assign link.rec   = rec_ff;

endmodule

>>> rtl/asj_timer.sv
module asj_timer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 load,
   input  asj_pkg::job_rec_type pop_rec,
   input  logic                 pop_last,
   input  logic                 rsp_taken,
   output logic                 rsp_valid,
   output asj_pkg::rsp_type     rsp
);
   import asj_pkg::*;

   logic [TIME_W-1:0] clock_time_ff, clock_time_in;
   logic [TIME_W-1:0] arr_ext, burst_ext, start_t;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   assign arr_ext   = TIME_W'(pop_rec.arr);
   assign burst_ext = TIME_W'(pop_rec.burst);
   assign start_t   = (clock_time_ff > arr_ext) ? clock_time_ff : arr_ext;

   always_comb begin
      clock_time_in = clock_time_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      if (rsp_taken) begin
         rsp_valid_in = 1'b0;
      end
      if (clear) begin
         clock_time_in = '0;
      end else if (load) begin
         // waiting is start minus arrival, so both sums run side by side
         rsp_in.rec        = pop_rec;
         rsp_in.completion = start_t + burst_ext;
         rsp_in.waiting    = start_t - arr_ext;
         rsp_in.turnaround = (start_t - arr_ext) + burst_ext;
         rsp_in.last       = pop_last;
         rsp_valid_in      = 1'b1;
         clock_time_in     = start_t + burst_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_time_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clock_time_ff <= clock_time_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
